/* src/assert_macros.svh */
// Assertion macros shared by the alarm timer RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

/* src/mst_pkg.sv */
// Shared types and constants of the multi-slot alarm timer.
// No dependencies; used by multi_slot_alarm_timer.
`timescale 1ns / 1ps

package mst_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int IDX_W       = $clog2(NUM_SLOTS);
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int TIME_W  = 64;
  localparam int DELAY_W = 32;
  localparam int CPM_W   = 20;
  localparam int PROD_W  = DELAY_W + CPM_W;

  localparam logic [CPM_W-1:0] CPM_RESET = CPM_W'(168000);

  // APB register map: one 32-bit register per word.
  localparam int PADDR_W = 3;
  localparam logic REG_CYCLES_PER_MS = 1'b0;

  typedef enum logic [3:0] {
    OP_INIT        = 4'd0,
    OP_DEINIT      = 4'd1,
    OP_ALLOCATE    = 4'd2,
    OP_FREE        = 4'd3,
    OP_ARM_ONESHOT = 4'd4,
    OP_ARM_PERIOD  = 4'd5,
    OP_DISARM      = 4'd6,
    OP_SUSPEND     = 4'd7,
    OP_RESUME      = 4'd8,
    OP_DISPATCH    = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_FIRE  = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  // One table entry; a period of zero marks a one-shot alarm.
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] period;
  } slot_timing_t;

endpackage

/* src/multi_slot_alarm_timer.sv */
// Top level of the multi-slot alarm timer: command decode, slot flags,
// timing memory and dispatch scan. Depends on mst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// Commands enter on the input channel (in_valid/in_stall with opcode, slot,
// arm_delay, now, key); results leave on the output channel (out_valid/
// out_stall with result_kind, slot_out, flag, last). One command is in work
// at a time and in_stall is high while it is.
// Most commands go from transfer to the reply state, which loads the result.
// Arm commands on a valid slot first multiply arm_delay by cycles_per_ms, then
// add now and write the timing memory, then present the reply. Dispatch reads
// the timing memory one slot per cycle while the output is not stalled; the
// single memory read port sets that rate.
// The next command is accepted in the cycle after the final result is loaded.
// Dispatch results are held back one slot so that last can be set on the
// final fire event, or on the "nothing due" result when no slot fires.
// A stalled output freezes the scan on the slot that needs to push a result;
// no state changes until the result is taken.
// Reset clears the flags, the output and the initialised bit, and loads
// cycles_per_ms with its default. The timing memory is not cleared: an entry is
// used only while its slot is armed, and arming writes it. The user must write
// cycles_per_ms over the APB port, byte address 0, only while idle; unenforced.

module multi_slot_alarm_timer (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [3:0]                        opcode,
  input  logic [2:0]                        slot,
  input  logic [mst_pkg::DELAY_W-1:0]       arm_delay,
  input  logic [mst_pkg::TIME_W-1:0]        now,
  input  logic                              key,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        result_kind,
  output logic [2:0]                        slot_out,
  output logic                              flag,
  output logic                              last,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mst_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_ARMW  = 6'b000100,
    ST_REPLY = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state;

  logic                                initialised;
  logic [mst_pkg::NUM_SLOTS-1:0]       in_use;
  logic [mst_pkg::NUM_SLOTS-1:0]       armed;
  logic [mst_pkg::NUM_SLOTS-1:0]       suspended;
  logic [mst_pkg::CPM_W-1:0]           cycles_per_ms;

  logic [3:0]                          cmd_op;
  logic [mst_pkg::IDX_W-1:0]           cmd_slot;
  logic [mst_pkg::DELAY_W-1:0]         cmd_delay;
  logic [mst_pkg::TIME_W-1:0]          cmd_now;
  logic [mst_pkg::PROD_W-1:0]          prod;
  logic                                rep_flag;
  logic [2:0]                          rep_slot;

  logic [mst_pkg::IDX_W-1:0]           scan_idx;
  logic                                pend_valid;
  logic [2:0]                          pend_slot;
  logic [mst_pkg::CNT_W-1:0]           fire_cnt;

  // Timing memory, one read and one write port, registered read data.
  mst_pkg::slot_timing_t               timing_mem [mst_pkg::NUM_SLOTS];
  mst_pkg::slot_timing_t               rd_data;
  logic [mst_pkg::IDX_W-1:0]           rd_addr;
  logic                                mem_we;
  logic [mst_pkg::IDX_W-1:0]           mem_wa;
  mst_pkg::slot_timing_t               mem_wd;

  logic                                accept;
  logic                                slot_ok;
  logic [mst_pkg::IDX_W-1:0]           slot_idx;
  logic                                free_found;
  logic [mst_pkg::IDX_W-1:0]           free_idx;
  logic                                eligible;
  logic                                due;
  logic                                fire;
  logic                                advance;
  logic                                out_free;
  logic                                out_load;
  logic [1:0]                          kind_next;
  logic [2:0]                          slot_out_next;
  logic                                flag_next;
  logic                                last_next;
  logic [mst_pkg::TIME_W-1:0]          add_b;
  logic [mst_pkg::TIME_W-1:0]          add_sum;
  logic                                cfg_write;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_idx  = slot[mst_pkg::IDX_W-1:0];
  assign slot_ok   = initialised && (32'(slot) < mst_pkg::NUM_SLOTS);
  assign out_free  = !out_valid || !out_stall;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == mst_pkg::REG_CYCLES_PER_MS) ?
                     32'(cycles_per_ms) : 32'd0;

  // Lowest free slot for allocate.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = mst_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = mst_pkg::IDX_W'(i);
      end
    end
  end

  // Scan evaluation on the entry whose read data is present this cycle.
  assign eligible = in_use[scan_idx] && armed[scan_idx] && !suspended[scan_idx]
                    && (fire_cnt < mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS));
  assign due      = (cmd_now >= rd_data.expiry);
  assign fire     = (state == ST_SCAN) && eligible && due;
  // A new fire pushes out the held one, which needs room at the output.
  assign advance  = !(fire && pend_valid && !out_free);

  // One adder serves the arm write and the periodic rearm.
  assign add_b   = (state == ST_ARMW) ? mst_pkg::TIME_W'(prod) : rd_data.period;
  assign add_sum = cmd_now + add_b;

  always_comb begin
    rd_addr = '0;
    if (state == ST_SCAN) begin
      rd_addr = advance ? scan_idx + 1'b1 : scan_idx;
    end
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_wa        = scan_idx;
    mem_wd.expiry = add_sum;
    mem_wd.period = rd_data.period;
    if (state == ST_ARMW) begin
      mem_we        = 1'b1;
      mem_wa        = cmd_slot;
      mem_wd.period = (cmd_op == mst_pkg::OP_ARM_PERIOD) ?
                      mst_pkg::TIME_W'(prod) : '0;
    end else if (fire && advance && (rd_data.period != '0)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      timing_mem[mem_wa] <= mem_wd;
    end
    rd_data <= timing_mem[rd_addr];
  end

  // Result selection for the output register.
  always_comb begin
    out_load      = 1'b0;
    kind_next     = mst_pkg::KIND_REPLY;
    slot_out_next = rep_slot;
    flag_next     = rep_flag;
    last_next     = 1'b1;
    case (state)
      ST_REPLY: begin
        out_load = out_free;
      end
      ST_SCAN: begin
        out_load      = fire && pend_valid && advance;
        kind_next     = mst_pkg::KIND_FIRE;
        slot_out_next = pend_slot;
        flag_next     = 1'b0;
        last_next     = 1'b0;
      end
      ST_FIN: begin
        out_load      = out_free;
        kind_next     = pend_valid ? mst_pkg::KIND_FIRE : mst_pkg::KIND_NONE;
        slot_out_next = pend_valid ? pend_slot : 3'd0;
        flag_next     = 1'b0;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind <= kind_next;
      slot_out    <= slot_out_next;
      flag        <= flag_next;
      last        <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      initialised   <= 1'b0;
      in_use        <= '0;
      armed         <= '0;
      suspended     <= '0;
      cycles_per_ms <= mst_pkg::CPM_RESET;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      fire_cnt      <= '0;
      scan_idx      <= '0;
    end else begin
      if (cfg_write && (paddr[2] == mst_pkg::REG_CYCLES_PER_MS)) begin
        cycles_per_ms <= pwdata[mst_pkg::CPM_W-1:0];
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_op    <= opcode;
            cmd_slot  <= slot_idx;
            cmd_delay <= arm_delay;
            cmd_now   <= now;
            rep_flag  <= 1'b0;
            rep_slot  <= 3'd0;
            state     <= ST_REPLY;
            case (opcode)
              mst_pkg::OP_INIT: begin
                if (!initialised) begin
                  initialised <= 1'b1;
                  in_use      <= '0;
                  armed       <= '0;
                  suspended   <= '0;
                end
              end
              mst_pkg::OP_DEINIT: begin
                initialised <= 1'b0;
              end
              mst_pkg::OP_ALLOCATE: begin
                if (initialised && free_found) begin
                  in_use[free_idx]    <= 1'b1;
                  armed[free_idx]     <= 1'b0;
                  suspended[free_idx] <= 1'b0;
                  rep_flag            <= 1'b1;
                  rep_slot            <= 3'(free_idx);
                end
              end
              mst_pkg::OP_FREE: begin
                if (slot_ok) begin
                  in_use[slot_idx] <= 1'b0;
                end
              end
              mst_pkg::OP_ARM_ONESHOT, mst_pkg::OP_ARM_PERIOD: begin
                if (slot_ok) begin
                  state <= ST_MUL;
                end
              end
              mst_pkg::OP_DISARM: begin
                if (slot_ok) begin
                  rep_flag        <= armed[slot_idx];
                  armed[slot_idx] <= 1'b0;
                end
              end
              mst_pkg::OP_SUSPEND: begin
                if (slot_ok) begin
                  rep_flag            <= suspended[slot_idx];
                  suspended[slot_idx] <= 1'b1;
                end
              end
              mst_pkg::OP_RESUME: begin
                if (slot_ok) begin
                  suspended[slot_idx] <= key;
                end
              end
              mst_pkg::OP_DISPATCH: begin
                scan_idx   <= '0;
                pend_valid <= 1'b0;
                fire_cnt   <= '0;
                state      <= initialised ? ST_SCAN : ST_FIN;
              end
              default: begin
                state <= ST_REPLY;
              end
            endcase
          end
        end
        ST_MUL: begin
          prod  <= mst_pkg::PROD_W'(cmd_delay) * mst_pkg::PROD_W'(cycles_per_ms);
          state <= ST_ARMW;
        end
        ST_ARMW: begin
          armed[cmd_slot] <= 1'b1;
          state           <= ST_REPLY;
        end
        ST_REPLY: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (advance) begin
            if (fire) begin
              fire_cnt   <= fire_cnt + 1'b1;
              pend_valid <= 1'b1;
              pend_slot  <= 3'(scan_idx);
              if (rd_data.period == '0) begin
                armed[scan_idx] <= 1'b0;
              end
            end
            if (scan_idx == mst_pkg::IDX_W'(mst_pkg::NUM_SLOTS - 1)) begin
              state <= ST_FIN;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result is never loaded over one that is still waiting to be taken.
  `ASSERT_NEVER(a_no_overwrite, clk, rst, out_load && out_valid && out_stall)
  // The timing memory is written only by an arm or a periodic rearm.
  `ASSERT_NEVER(a_mem_we_state, clk, rst,
                mem_we && !(state == ST_ARMW || state == ST_SCAN))
  // An accepted command keeps the block busy in the next cycle.
  `ASSERT_ALWAYS(a_busy_after_accept, clk, rst, accept |=> in_stall)
  // The number of fire events of one dispatch stays within the limit.
  `ASSERT_ALWAYS(a_fire_limit, clk, rst,
                 fire_cnt <= mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS))

endmodule
